@@ rtl/gpi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gpi_pkg;

  localparam int ENTRY_W    = 8;
  localparam int KEY_IDX_W  = 6;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int COLOR_W    = NUM_CH * CH_W;
  localparam int SIZE_W     = 8;
  localparam int COUNT_W    = 7;
  localparam int LIMIT_W    = SIZE_W + COUNT_W;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_CMP_W       = 13;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 8'd8;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd31;

  localparam logic [CFG_ADDR_W-1:0] REG_SEGMENT_SIZE  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SEGMENT_COUNT = 1'd1;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Restoring divider: 8-bit quotient, two quotient bits per stage
  localparam int DIV_W      = 8;
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEP   = DIV_W / DIV_STAGES;

  typedef struct packed {
    logic                 func;
    logic [KEY_IDX_W-1:0] key_index;
    logic [CH_W-1:0]      key_red;
    logic [CH_W-1:0]      key_green;
    logic [CH_W-1:0]      key_blue;
    logic [ENTRY_W-1:0]   entry_index;
  } request_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            out_of_range;
  } result_t;

  typedef struct packed {
    logic                 lookup;
    logic                 out_of_range;
    logic [KEY_IDX_W-1:0] key_index;
    logic [COLOR_W-1:0]   color;
  } seg_side_t;

  typedef struct packed {
    logic                 en;
    logic [KEY_IDX_W-1:0] key_index;
    logic [COLOR_W-1:0]   color;
  } key_wr_t;

endpackage

`default_nettype wire

@@ rtl/gradient_palette_interpolator_top.sv @@
// Channel   Ports                          Transfer
// --------  -----------------------------  ---------------------------------------
// request   start, busy, request           taken when start is high and busy is low
// result    done, result                   one cycle per transaction, no back-pressure
// config    cfg_write, cfg_addr, cfg_data  taken when cfg_write is high
//
// One transaction enters per clock; busy never rises. A lookup's result shows
// on done after the input register, four stages of the entry/size divider,
// the key table read, multiply, sum and four stages of the channel divider,
// then the output register. Key writes take effect at the table read stage,
// so a later lookup always sees them. Reset marks every key slot black and
// loads segment size 8 and count 31.
`timescale 1ns / 1ps
`default_nettype none

module gradient_palette_interpolator_top
  import gpi_pkg::*;
#(
  parameter int MAX_KEYS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  request_t              request,
  output logic                  busy,
  input  logic                  cfg_write,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output result_t               result
);

  localparam int AW    = $clog2(MAX_KEYS);
  localparam int SBW   = $bits(seg_side_t);
  localparam int CMP_W = COUNT_W + 2;

  logic [SIZE_W-1:0]  seg_size;
  logic [COUNT_W-1:0] seg_count;
  logic [SIZE_W-1:0]  size_next, size_eff;
  logic [COUNT_W-1:0] count_nz, count_next, count_eff;
  logic [LIMIT_W-1:0] limit;

  logic               accept;
  logic               a_vld;
  request_t           a_req;
  logic               a_oor;
  seg_side_t          a_side;

  logic               s_vld;
  logic [DIV_W-1:0]   s_q, s_rem;
  seg_side_t          s_side;
  logic [ENTRY_W:0]   s_inc;
  logic [ENTRY_W-1:0] s_nx;
  key_wr_t            key_wr;
  logic [COLOR_W-1:0] key_a, key_b;

  logic               r_vld, r_oor;
  logic [ENTRY_W-1:0] r_pos;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_size  <= SIZE_RESET;
      seg_count <= COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_addr)
        REG_SEGMENT_SIZE:  seg_size  <= cfg_data[SIZE_W-1:0];
        REG_SEGMENT_COUNT: seg_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero size or count acts as one; count is capped at the table depth
  assign size_next  = (seg_size == '0) ? SIZE_W'(1) : seg_size;
  assign count_nz   = (seg_count == '0) ? COUNT_W'(1) : seg_count;
  assign count_next = ({2'b0, count_nz} > CMP_W'(MAX_KEYS)) ? COUNT_W'(MAX_KEYS) : count_nz;

  always_ff @(posedge clk) begin
    size_eff  <= size_next;
    count_eff <= count_next;
    limit     <= LIMIT_W'(size_next) * LIMIT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    a_req <= request;
  end

  assign a_oor = (LIMIT_W'(a_req.entry_index) >= limit) ||
                 (PAL_CMP_W'(a_req.entry_index) >= PAL_CMP_W'(PALETTE_ENTRIES));

  always_comb begin
    a_side.lookup       = (a_req.func == FUNC_LOOKUP);
    a_side.out_of_range = a_oor;
    a_side.key_index    = a_req.key_index;
    a_side.color        = {a_req.key_red, a_req.key_green, a_req.key_blue};
  end

  // segment = entry / size, position = entry % size
  gpi_div #(.LANES(1), .SBW(SBW)) u_seg_div (
    .clk       (clk),
    .rst       (rst),
    .valid     (a_vld),
    .hi        ('0),
    .lo        (a_req.entry_index),
    .divisor   (size_eff),
    .side      (a_side),
    .q_valid   (s_vld),
    .quotient  (s_q),
    .remainder (s_rem),
    .q_side    (s_side)
  );

  // last segment wraps back to key 0
  assign s_inc = {1'b0, s_q} + (ENTRY_W+1)'(1);
  assign s_nx  = (s_inc >= (ENTRY_W+1)'(count_eff)) ? '0 : s_inc[ENTRY_W-1:0];

  always_comb begin
    key_wr.en        = s_vld && (s_side.lookup == FUNC_WRITE);
    key_wr.key_index = s_side.key_index;
    key_wr.color     = s_side.color;
  end

  gpi_key_store #(.MAX_KEYS(MAX_KEYS)) u_keys (
    .clk    (clk),
    .rst    (rst),
    .wr     (key_wr),
    .addr_a (s_q[AW-1:0]),
    .addr_b (s_nx[AW-1:0]),
    .key_a  (key_a),
    .key_b  (key_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld <= 1'b0;
    end else begin
      r_vld <= s_vld && s_side.lookup;
    end
  end

  always_ff @(posedge clk) begin
    r_oor <= s_side.out_of_range;
    r_pos <= s_rem;
  end

  gpi_lerp u_lerp (
    .clk    (clk),
    .rst    (rst),
    .valid  (r_vld),
    .oor    (r_oor),
    .size   (size_eff),
    .pos    (r_pos),
    .key_a  (key_a),
    .key_b  (key_b),
    .done   (done),
    .result (result)
  );

endmodule

`default_nettype wire

@@ rtl/gpi_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gpi_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/gpi_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gpi_div
  import gpi_pkg::*;
#(
  parameter int LANES = 1,
  parameter int SBW   = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         valid,
  input  logic [LANES-1:0][DIV_W-1:0]  hi,
  input  logic [LANES-1:0][DIV_W-1:0]  lo,
  input  logic [DIV_W-1:0]             divisor,
  input  logic [SBW-1:0]               side,
  output logic                         q_valid,
  output logic [LANES-1:0][DIV_W-1:0]  quotient,
  output logic [LANES-1:0][DIV_W-1:0]  remainder,
  output logic [SBW-1:0]               q_side
);

  logic [DIV_STAGES-1:0]                         st_vld;
  logic [DIV_STAGES-1:0][LANES-1:0][DIV_W-1:0]   st_rem, st_lo, st_q;
  logic [DIV_STAGES-1:0][DIV_W-1:0]              st_d;
  logic [DIV_STAGES-1:0][SBW-1:0]                st_sb;

  logic [DIV_STAGES-1:0][LANES-1:0][DIV_W-1:0]   src_rem, src_lo, src_q;
  logic [DIV_STAGES-1:0][DIV_W-1:0]              src_d;
  logic [DIV_STAGES-1:0][SBW-1:0]                src_sb;
  logic [DIV_STAGES-1:0][LANES-1:0][DIV_W-1:0]   nxt_rem, nxt_lo, nxt_q;

  // stage k works on what stage k-1 left; stage 0 on the inputs
  always_comb begin
    src_rem[0] = hi;
    src_lo[0]  = lo;
    src_q[0]   = '0;
    src_d[0]   = divisor;
    src_sb[0]  = side;
    for (int k = 1; k < DIV_STAGES; k++) begin
      src_rem[k] = st_rem[k-1];
      src_lo[k]  = st_lo[k-1];
      src_q[k]   = st_q[k-1];
      src_d[k]   = st_d[k-1];
      src_sb[k]  = st_sb[k-1];
    end
  end

  // remainder stays below the divisor, so each trial fits DIV_W+1 bits
  always_comb begin
    logic [DIV_W:0]   trial;
    logic [DIV_W-1:0] r;
    logic [DIV_W-1:0] bits;
    logic [DIV_W-1:0] q;
    trial = '0;
    r     = '0;
    bits  = '0;
    q     = '0;
    for (int k = 0; k < DIV_STAGES; k++) begin
      for (int l = 0; l < LANES; l++) begin
        r    = src_rem[k][l];
        bits = src_lo[k][l];
        q    = src_q[k][l];
        for (int j = 0; j < DIV_STEP; j++) begin
          trial = {r, bits[DIV_W-1]};
          bits  = {bits[DIV_W-2:0], 1'b0};
          if (trial >= {1'b0, src_d[k]}) begin
            r = DIV_W'(trial - {1'b0, src_d[k]});
            q = {q[DIV_W-2:0], 1'b1};
          end else begin
            r = trial[DIV_W-1:0];
            q = {q[DIV_W-2:0], 1'b0};
          end
        end
        nxt_rem[k][l] = r;
        nxt_lo[k][l]  = bits;
        nxt_q[k][l]   = q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld <= '0;
    end else begin
      st_vld <= {st_vld[DIV_STAGES-2:0], valid};
    end
  end

  always_ff @(posedge clk) begin
    st_rem <= nxt_rem;
    st_lo  <= nxt_lo;
    st_q   <= nxt_q;
    st_d   <= src_d;
    st_sb  <= src_sb;
  end

  assign q_valid   = st_vld[DIV_STAGES-1];
  assign quotient  = st_q[DIV_STAGES-1];
  assign remainder = st_rem[DIV_STAGES-1];
  assign q_side    = st_sb[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ rtl/gpi_key_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gpi_key_store
  import gpi_pkg::*;
#(
  parameter int MAX_KEYS = 64,
  localparam int AW = $clog2(MAX_KEYS)
) (
  input  logic               clk,
  input  logic               rst,
  input  key_wr_t            wr,
  input  logic [AW-1:0]      addr_a,
  input  logic [AW-1:0]      addr_b,
  output logic [COLOR_W-1:0] key_a,
  output logic [COLOR_W-1:0] key_b
);

  localparam int XW = (AW > KEY_IDX_W) ? AW : KEY_IDX_W;

  logic [XW-1:0]       wr_idx;
  logic                wr_ok;
  logic [AW-1:0]       wr_addr;
  logic [MAX_KEYS-1:0] filled;
  logic                hit_a, hit_b;
  logic [COLOR_W-1:0]  data_a, data_b;

  // drop writes to slots beyond the table
  assign wr_idx  = XW'(wr.key_index);
  assign wr_ok   = wr.en && ({1'b0, wr_idx} < (XW+1)'(MAX_KEYS));
  assign wr_addr = wr_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (wr_ok) begin
      filled[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    hit_a <= filled[addr_a];
    hit_b <= filled[addr_b];
  end

  // two copies give two read ports
  gpi_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_KEYS)) u_ram_a (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (wr_addr),
    .wdata (wr.color),
    .raddr (addr_a),
    .rdata (data_a)
  );

  gpi_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_KEYS)) u_ram_b (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (wr_addr),
    .wdata (wr.color),
    .raddr (addr_b),
    .rdata (data_b)
  );

  // a slot never written since reset reads as black
  assign key_a = hit_a ? data_a : '0;
  assign key_b = hit_b ? data_b : '0;

endmodule

`default_nettype wire

@@ rtl/gpi_lerp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gpi_lerp
  import gpi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  input  logic               oor,
  input  logic [SIZE_W-1:0]  size,
  input  logic [ENTRY_W-1:0] pos,
  input  logic [COLOR_W-1:0] key_a,
  input  logic [COLOR_W-1:0] key_b,
  output logic               done,
  output result_t            result
);

  localparam int PW = 2 * CH_W;

  logic [SIZE_W-1:0]                 w_a;
  logic                              m_vld, m_oor;
  logic [NUM_CH-1:0][PW-1:0]         m_pa, m_pb;
  logic                              n_vld, n_oor;
  logic [NUM_CH-1:0][PW-1:0]         n_num;
  logic [NUM_CH-1:0][DIV_W-1:0]      d_hi, d_lo;
  logic                              q_vld, q_oor;
  logic [NUM_CH-1:0][DIV_W-1:0]      q_val;

  // pos is below size, so the weight never wraps
  assign w_a = size - SIZE_W'(pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
      n_vld <= 1'b0;
    end else begin
      m_vld <= valid;
      n_vld <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    m_oor <= oor;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      m_pa[ch] <= PW'(key_a[(NUM_CH-1-ch)*CH_W +: CH_W]) * PW'(w_a);
      m_pb[ch] <= PW'(key_b[(NUM_CH-1-ch)*CH_W +: CH_W]) * PW'(pos);
    end
    n_oor <= m_oor;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      n_num[ch] <= m_pa[ch] + m_pb[ch];
    end
  end

  // numerator is at most 255*size, so its upper byte is below size
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      d_hi[ch] = n_num[ch][PW-1:CH_W];
      d_lo[ch] = n_num[ch][CH_W-1:0];
    end
  end

  gpi_div #(.LANES(NUM_CH), .SBW(1)) u_div (
    .clk       (clk),
    .rst       (rst),
    .valid     (n_vld),
    .hi        (d_hi),
    .lo        (d_lo),
    .divisor   (size),
    .side      (n_oor),
    .q_valid   (q_vld),
    .quotient  (q_val),
    .remainder (),
    .q_side    (q_oor)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    result.red          <= q_oor ? '0 : q_val[0];
    result.green        <= q_oor ? '0 : q_val[1];
    result.blue         <= q_oor ? '0 : q_val[2];
    result.out_of_range <= q_oor;
  end

endmodule

`default_nettype wire
